@@ src/tvcc_pkg.sv @@
// shared constants, register indexes and state type for the velocity constraint cost unit
`default_nettype none
package tvcc_pkg;
    localparam int VEL_WIDTH = 16;
    localparam int MAXW      = (VEL_WIDTH > 16) ? VEL_WIDTH : 16;
    localparam int PEN_W     = MAXW + 2;
    localparam int SQ_W      = 2 * VEL_WIDTH;
    localparam int SREM_W    = VEL_WIDTH + 4;
    localparam int RAD_W     = VEL_WIDTH + 12;
    localparam int SQRT_ITERS = VEL_WIDTH;
    localparam int DIV_ITERS = RAD_W;
    localparam int CNT_W     = $clog2(DIV_ITERS + 1);
    localparam int TERM_W    = PEN_W + 16;
    localparam int SUM_W     = 48;
    localparam int HALF_W    = SUM_W / 2;
    localparam int COST_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [14:0] MAX_SPEED_RST = 15'd3277;
    localparam logic [15:0] MIN_SPEED_RST = 16'hFA66;
    localparam logic [15:0] STEP_TIME_RST = 16'd3277;
    localparam logic [15:0] WEIGHT_RST    = 16'd1024;
    localparam logic [2:0]  POWER_RST     = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 4'd0,
        CFG_MAX_SPEED  = 4'd1,
        CFG_MIN_SPEED  = 4'd2,
        CFG_TURN_MODE  = 4'd3,
        CFG_MIN_RADIUS = 4'd4,
        CFG_STEP_TIME  = 4'd5,
        CFG_WEIGHT     = 4'd6,
        CFG_POWER      = 4'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ITER,
        ST_PEN,
        ST_ACC,
        ST_W_LO,
        ST_W_HI,
        ST_W_SAT,
        ST_POW,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

@@ src/tvcc_if.sv @@
// handshake channel interfaces: step input, cost output, configuration write
`default_nettype none
interface tvcc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tvcc_pkg::VEL_WIDTH-1:0] vel_x;
    logic signed [tvcc_pkg::VEL_WIDTH-1:0] vel_y;
    logic signed [tvcc_pkg::VEL_WIDTH-1:0] yaw_rate;
    logic                                last_step;
    logic [31:0]                         cost_in;
    modport source (output valid, vel_x, vel_y, yaw_rate, last_step, cost_in, input ready);
    modport sink   (input valid, vel_x, vel_y, yaw_rate, last_step, cost_in, output ready);
endinterface

interface tvcc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cost_out;
    modport source (output valid, cost_out, input ready);
    modport sink   (input valid, cost_out, output ready);
endinterface

interface tvcc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tvcc_pkg::CFG_IDX_W-1:0]      index;
    logic [tvcc_pkg::CFG_DAT_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/trajectory_velocity_constraint_cost_unit.sv @@
// Velocity constraint cost: one trajectory step per input transaction. Each step is accepted,
// forms vx^2 + vy^2 (ST_SQ_X, ST_SQ_Y), then runs a shared loop (ST_ITER) in which a radix-2
// square root and a radix-2 restoring divider for the turning radius run side by side, then
// forms the penalty and accumulates it (ST_PEN, ST_ACC); the next step is accepted only after
// that. A last step adds weighting (ST_W_LO, ST_W_HI, ST_W_SAT), raising to the effective
// power (1 to 4) in ST_POW, and a load of the cost output register; the output holds until
// taken and a last step waits in ST_DONE for the previous cost to be taken. Disabled, a step
// is accepted with no work, and a last step loads cost_in unchanged into the output register.
`default_nettype none
module trajectory_velocity_constraint_cost_unit (
    input  wire       i_clk,
    input  wire       i_rst_n,
    tvcc_in_if.sink   i_in,
    tvcc_cfg_if.sink  i_cfg,
    tvcc_out_if.source o_out
);
    import tvcc_pkg::*;

    t_state r_state, n_state;

    logic              r_enable;
    logic [14:0]       r_max_speed;
    logic [15:0]       r_min_speed;
    logic              r_turn_mode;
    logic [15:0]       r_min_radius;
    logic [15:0]       r_step_time;
    logic [15:0]       r_weight;
    logic [2:0]        r_power;

    logic [VEL_WIDTH-1:0] r_ax, r_ay, r_aw;
    logic              r_vx_pos, r_wz_nz, r_last;
    logic [COST_W-1:0] r_cost_in;
    logic [SQ_W-1:0]   r_sqin;
    logic [SREM_W-1:0] r_srem;
    logic [VEL_WIDTH-1:0] r_root;
    logic [RAD_W-1:0]  r_num;
    logic [VEL_WIDTH-1:0] r_drem;
    logic [CNT_W-1:0]  r_cnt;
    logic [PEN_W-1:0]  r_pen;
    logic [SUM_W-1:0]  r_sum;
    logic [63:0]       r_wprod;
    logic [COST_W-1:0] r_x, r_y;
    logic [1:0]        r_pcnt;
    logic              r_ovalid;
    logic [COST_W-1:0] r_cost_out;

    logic [VEL_WIDTH-1:0] in_ax, in_ay, in_aw;
    logic [SREM_W-1:0] srem_sh, strial;
    logic [VEL_WIDTH:0] dsh;
    logic              qbit;
    logic signed [PEN_W-1:0] spd, mag_s, max_s, mn_s, p1, p2;
    logic [RAD_W-1:0]  mtr_ext;
    logic [15:0]       rt;
    logic [PEN_W-1:0]  pen;
    logic [TERM_W-1:0] term;
    logic [SUM_W:0]    sum_add;
    logic [63:0]       pw_prod;
    logic [43:0]       wx;
    logic [2:0]        pw_eff;
    logic [COST_W:0]   cost_add;
    logic              out_free;

    assign in_ax = i_in.vel_x[VEL_WIDTH-1] ? VEL_WIDTH'(-i_in.vel_x) : VEL_WIDTH'(i_in.vel_x);
    assign in_ay = i_in.vel_y[VEL_WIDTH-1] ? VEL_WIDTH'(-i_in.vel_y) : VEL_WIDTH'(i_in.vel_y);
    assign in_aw = i_in.yaw_rate[VEL_WIDTH-1] ? VEL_WIDTH'(-i_in.yaw_rate)
                                              : VEL_WIDTH'(i_in.yaw_rate);

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_ovalid;
    assign o_out.cost_out = r_cost_out;
    assign out_free     = !r_ovalid || o_out.ready;

    // sqrt digit step: two radicand bits a cycle
    assign srem_sh = {r_srem[SREM_W-3:0], r_sqin[SQ_W-1 -: 2]};
    assign strial  = {2'b00, r_root, 2'b01};
    // restoring divide step, quotient shifts into r_num
    assign dsh     = {r_drem, r_num[RAD_W-1]};
    assign qbit    = (dsh >= {1'b0, r_aw});

    always_comb begin
        mag_s = $signed({{(PEN_W-VEL_WIDTH){1'b0}}, r_root});
        spd   = r_vx_pos ? mag_s : -mag_s;
        max_s = $signed({{(PEN_W-15){1'b0}}, r_max_speed});
        mn_s  = $signed({{(PEN_W-16){r_min_speed[15]}}, r_min_speed});
        p1    = (spd > max_s) ? (spd - max_s) : '0;
        p2    = (mn_s > spd) ? (mn_s - spd) : '0;
        mtr_ext = {{(RAD_W-16){1'b0}}, r_min_radius};
        rt    = (r_turn_mode && r_wz_nz && (mtr_ext > r_num)) ? 16'(mtr_ext - r_num) : 16'd0;
        pen   = PEN_W'(p1) + PEN_W'(p2) + {{(PEN_W-16){1'b0}}, rt};
    end

    assign term    = r_pen * r_step_time;
    assign sum_add = {1'b0, r_sum} + {{(SUM_W+1-TERM_W){1'b0}}, term};
    assign wx      = r_wprod[63:20];
    assign pw_prod = r_y * r_x;
    assign pw_eff  = (r_power == 3'd0) ? 3'd1 : ((r_power > 3'd4) ? 3'd4 : r_power);
    assign cost_add = {1'b0, r_cost_in} + {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (r_enable)             n_state = ST_SQ_X;
                    else if (i_in.last_step)  n_state = ST_DONE;
                end
            end
            ST_SQ_X:  n_state = ST_SQ_Y;
            ST_SQ_Y:  n_state = ST_ITER;
            ST_ITER:  if (r_cnt == CNT_W'(DIV_ITERS - 1)) n_state = ST_PEN;
            ST_PEN:   n_state = ST_ACC;
            ST_ACC:   n_state = r_last ? ST_W_LO : ST_IDLE;
            ST_W_LO:  n_state = ST_W_HI;
            ST_W_HI:  n_state = ST_W_SAT;
            ST_W_SAT: n_state = ST_POW;
            ST_POW:   if (r_pcnt == 2'd0) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_max_speed  <= MAX_SPEED_RST;
            r_min_speed  <= MIN_SPEED_RST;
            r_turn_mode  <= 1'b0;
            r_min_radius <= 16'd0;
            r_step_time  <= STEP_TIME_RST;
            r_weight     <= WEIGHT_RST;
            r_power      <= POWER_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ENABLE:     r_enable     <= i_cfg.data[0];
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg.data[14:0];
                CFG_MIN_SPEED:  r_min_speed  <= i_cfg.data;
                CFG_TURN_MODE:  r_turn_mode  <= i_cfg.data[0];
                CFG_MIN_RADIUS: r_min_radius <= i_cfg.data;
                CFG_STEP_TIME:  r_step_time  <= i_cfg.data;
                CFG_WEIGHT:     r_weight     <= i_cfg.data;
                CFG_POWER:      r_power      <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // control: penalty sum and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_ACC)
                r_sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            else if (r_state == ST_DONE && out_free)
                r_sum <= '0;
            if (r_state == ST_DONE && out_free)
                r_ovalid <= 1'b1;
            else if (o_out.ready)
                r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ax      <= in_ax;
                r_ay      <= in_ay;
                r_aw      <= in_aw;
                r_vx_pos  <= !i_in.vel_x[VEL_WIDTH-1] && (i_in.vel_x != '0);
                r_wz_nz   <= (i_in.yaw_rate != '0);
                r_last    <= i_in.last_step;
                r_cost_in <= i_in.cost_in;
                r_y       <= '0;
            end
            ST_SQ_X: begin
                r_sqin <= r_ax * r_ax;
            end
            ST_SQ_Y: begin
                r_sqin <= r_sqin + SQ_W'(r_ay * r_ay);
                r_srem <= '0;
                r_root <= '0;
                r_num  <= {r_ax, 12'd0};
                r_drem <= '0;
                r_cnt  <= '0;
            end
            ST_ITER: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt < CNT_W'(SQRT_ITERS)) begin
                    r_sqin <= {r_sqin[SQ_W-3:0], 2'b00};
                    if (srem_sh >= strial) begin
                        r_srem <= srem_sh - strial;
                        r_root <= {r_root[VEL_WIDTH-2:0], 1'b1};
                    end else begin
                        r_srem <= srem_sh;
                        r_root <= {r_root[VEL_WIDTH-2:0], 1'b0};
                    end
                end
                r_drem <= qbit ? VEL_WIDTH'(dsh - {1'b0, r_aw}) : VEL_WIDTH'(dsh);
                r_num  <= {r_num[RAD_W-2:0], qbit};
            end
            ST_PEN: begin
                r_pen <= pen;
            end
            ST_W_LO: begin
                r_wprod <= 64'(r_sum[HALF_W-1:0] * r_weight);
            end
            ST_W_HI: begin
                r_wprod <= r_wprod
                         + {(64-HALF_W)'(r_sum[SUM_W-1:HALF_W] * r_weight), {HALF_W{1'b0}}};
            end
            ST_W_SAT: begin
                r_x    <= (|wx[43:32]) ? {COST_W{1'b1}} : wx[31:0];
                r_y    <= (|wx[43:32]) ? {COST_W{1'b1}} : wx[31:0];
                r_pcnt <= 2'(pw_eff - 3'd1);
            end
            ST_POW: begin
                if (r_pcnt != 2'd0) begin
                    r_y    <= (|pw_prod[63:48]) ? {COST_W{1'b1}} : pw_prod[47:16];
                    r_pcnt <= r_pcnt - 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free)
                    r_cost_out <= cost_add[COST_W] ? {COST_W{1'b1}} : cost_add[COST_W-1:0];
            end
            default: ;
        endcase
    end

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ITER) |-> (r_cnt < CNT_W'(DIV_ITERS)))
        else $error("iteration counter overran");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_sum == '0))
        else $error("penalty sum not cleared after last step");

    // a waiting cost transaction stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.cost_out)))
        else $error("cost output changed while stalled");
endmodule
`default_nettype wire

@@ tb/tvcc_tb_if.sv @@
// testbench package with the packed record of one trajectory step
`timescale 1ns / 1ps
`default_nettype none
package tvcc_tb_types;
    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] wz;
        logic               last;
        logic [31:0]        cost;
    } t_step;
endpackage
`default_nettype wire

@@ tb/tb_trajectory_velocity_constraint_cost_unit.sv @@
// testbench for the velocity constraint cost unit: random steps, config sweeps, cost prediction
`timescale 1ns / 1ps
`default_nettype none
module tb_trajectory_velocity_constraint_cost_unit;
    import tvcc_pkg::*;
    import tvcc_tb_types::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    tvcc_in_if  in_ch ();
    tvcc_out_if out_ch ();
    tvcc_cfg_if cfg_ch ();

    trajectory_velocity_constraint_cost_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_cfg(cfg_ch.sink),
        .o_out(out_ch.source)
    );

    // predictor copy of the registers and accumulator
    logic        m_enable;
    logic [14:0] m_max_speed;
    logic [15:0] m_min_speed;
    logic        m_turn;
    logic [15:0] m_radius;
    logic [15:0] m_dt;
    logic [15:0] m_weight;
    logic [2:0]  m_power;
    logic [47:0] m_sum;

    logic [31:0] cost_queue[$];
    int  errors = 0;
    int  n_steps = 0;
    int  n_costs = 0;
    longint cycles = 0;
    logic stall_en = 1'b1;

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    task automatic predict_cost(input t_step s);
        longint ax, ay, mag, spd, mn, aw, rad;
        longint unsigned pen, term, x, y, c, lim, p;
        lim = 64'hFFFF_FFFF;
        c = s.cost;
        if (m_enable) begin
            ax = (s.vx < 0) ? -longint'(s.vx) : longint'(s.vx);
            ay = (s.vy < 0) ? -longint'(s.vy) : longint'(s.vy);
            mag = longint'(isqrt(ax * ax + ay * ay));
            spd = (s.vx > 0) ? mag : -mag;
            mn = longint'($signed(m_min_speed));
            pen = 0;
            if (spd > longint'(m_max_speed)) pen += spd - longint'(m_max_speed);
            if (mn > spd) pen += mn - spd;
            if (m_turn && s.wz != 0) begin
                aw = (s.wz < 0) ? -longint'(s.wz) : longint'(s.wz);
                rad = (ax << 12) / aw;
                if (longint'(m_radius) > rad) pen += longint'(m_radius) - rad;
            end
            term = pen * m_dt;
            if (term > 64'hFFFF_FFFF_FFFF - m_sum) m_sum = 48'hFFFF_FFFF_FFFF;
            else m_sum = m_sum + term[47:0];
        end
        if (s.last) begin
            if (m_enable) begin
                x = (64'(m_sum) * m_weight) >> 20;
                if (x > lim) x = lim;
                p = (m_power == 0) ? 1 : ((m_power > 4) ? 4 : m_power);
                y = x;
                for (int i = 1; i < p; i++) begin
                    y = (y * x) >> 16;
                    if (y > lim) y = lim;
                end
                c = c + y;
                if (c > lim) c = lim;
            end
            m_sum = 0;
            cost_queue.push_back(c[31:0]);
        end
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!stall_en || r < 50) return;
        in_ch.valid <= 1'b0;
        repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge i_clk);
    endtask

    // valid stays high into the next transaction unless a gap or an idle wait drops it
    task automatic send_step(input t_step s);
        random_gap();
        in_ch.valid     <= 1'b1;
        in_ch.vel_x     <= s.vx;
        in_ch.vel_y     <= s.vy;
        in_ch.yaw_rate  <= s.wz;
        in_ch.last_step <= s.last;
        in_ch.cost_in   <= s.cost;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_cost(s);
        n_steps++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (cost_queue.size() != 0) @(posedge i_clk);
        // non-last steps push no expected cost, so an empty queue does not cover them
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLE:     m_enable = val[0];
            CFG_MAX_SPEED:  m_max_speed = val[14:0];
            CFG_MIN_SPEED:  m_min_speed = val;
            CFG_TURN_MODE:  m_turn = val[0];
            CFG_MIN_RADIUS: m_radius = val;
            CFG_STEP_TIME:  m_dt = val;
            CFG_WEIGHT:     m_weight = val;
            CFG_POWER:      m_power = val[2:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_vel();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 12000)) - 6000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_trajectory(input int len);
        t_step s;
        for (int i = 0; i < len; i++) begin
            s.vx = pick_vel();
            s.vy = pick_vel();
            s.wz = ($urandom_range(0, 7) == 0) ? 16'sd0 : pick_vel();
            s.last = (i == len - 1);
            s.cost = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                 : $urandom;
            send_step(s);
        end
    endtask

    // checker on the cost channel
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (cost_queue.size() == 0) begin
                $display("%0t: unexpected cost transaction, actual %h", $time, out_ch.cost_out);
                errors++;
            end else begin
                if (out_ch.cost_out !== cost_queue[0]) begin
                    $display("%0t: cost_out mismatch expected %h actual %h", $time,
                             cost_queue[0], out_ch.cost_out);
                    errors++;
                end
                void'(cost_queue.pop_front());
                n_costs++;
            end
        end
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (!stall_en) out_ch.ready <= 1'b1;
        else if ($urandom_range(0, 99) < 8) out_ch.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 60) out_ch.ready <= 1'b1;
        if (cycles > 3000000) begin
            $display("trajectory_velocity_constraint_cost_unit test failed");
            $finish;
        end
    end

    task automatic test_directed();
        t_step s;
        logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001};
        for (int i = 0; i < 4; i++) begin
            s = '{vx: ext[i], vy: ext[3 - i], wz: ext[i], last: 1'b0, cost: 32'h0};
            send_step(s);
        end
        s = '{vx: 16'h7FFF, vy: 16'h7FFF, wz: 16'h0000, last: 1'b1, cost: 32'hFFFF_FFFF};
        send_step(s);
        s = '{vx: 16'h0000, vy: 16'h0000, wz: 16'h0000, last: 1'b1, cost: 32'h0};
        send_step(s);
        wait_idle();
        write_reg(CFG_TURN_MODE, 16'd1);
        write_reg(CFG_MIN_RADIUS, 16'hFFFF);
        write_reg(CFG_POWER, 16'd0);
        s = '{vx: 16'h1000, vy: 16'h0, wz: 16'h0, last: 1'b0, cost: 32'h0};
        send_step(s);
        s = '{vx: 16'hF000, vy: 16'h0, wz: 16'h8000, last: 1'b1, cost: 32'h1234_5678};
        send_step(s);
        wait_idle();
        write_reg(CFG_POWER, 16'd7);
        write_reg(CFG_WEIGHT, 16'hFFFF);
        write_reg(CFG_ENABLE, 16'hFFFE);
        s = '{vx: 16'h7FFF, vy: 16'h0, wz: 16'h1, last: 1'b0, cost: 32'h0};
        send_step(s);
        s = '{vx: 16'h7FFF, vy: 16'h0, wz: 16'h1, last: 1'b1, cost: 32'hA5A5_A5A5};
        send_step(s);
        wait_idle();
        write_reg(CFG_ENABLE, 16'd1);
        send_trajectory(4);
        wait_idle();
    endtask

    task automatic test_random();
        int total;
        total = 0;
        while (total < 440) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
            send_trajectory(len);
            total += len;
            if ($urandom_range(0, 9) == 0) begin
                wait_idle();
                write_reg(CFG_ENABLE, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'd1);
                write_reg(CFG_MAX_SPEED, ($urandom_range(0, 3) == 0) ?
                          (($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h0) : 16'($urandom));
                write_reg(CFG_MIN_SPEED, ($urandom_range(0, 3) == 0) ?
                          (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF) : 16'($urandom));
                write_reg(CFG_TURN_MODE, 16'($urandom_range(0, 1)));
                write_reg(CFG_MIN_RADIUS, 16'($urandom));
                write_reg(CFG_STEP_TIME, ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom));
                write_reg(CFG_WEIGHT, ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom));
                write_reg(CFG_POWER, 16'($urandom_range(0, 7)));
            end
            // stalls are switched off for the next stretch one time in eight
            stall_en = ($urandom_range(0, 7) != 0);
        end
        stall_en = 1'b1;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.vel_x = '0;
        in_ch.vel_y = '0;
        in_ch.yaw_rate = '0;
        in_ch.last_step = 1'b0;
        in_ch.cost_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        m_enable = 1'b1;
        m_max_speed = MAX_SPEED_RST;
        m_min_speed = MIN_SPEED_RST;
        m_turn = 1'b0;
        m_radius = '0;
        m_dt = STEP_TIME_RST;
        m_weight = WEIGHT_RST;
        m_power = POWER_RST;
        m_sum = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        wait_idle();
        $display("covered %0d steps and %0d trajectory costs", n_steps, n_costs);
        $display("across register sweeps incl. disabled, turn mode and power extremes");
        if (errors == 0) begin
            $display("trajectory_velocity_constraint_cost_unit test passed");
        end else begin
            $display("trajectory_velocity_constraint_cost_unit test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
src/tvcc_pkg.sv
src/tvcc_if.sv
src/trajectory_velocity_constraint_cost_unit.sv
tb/tvcc_tb_if.sv
tb/tb_trajectory_velocity_constraint_cost_unit.sv
